// ===== hdl/cmvm_pkg.sv =====
package cmvm_pkg;

	localparam int DATA_W    = 32;  // Q16.16 operand
	localparam int ACC_W     = 64;  // Q32.32 accumulator
	localparam int ROW_W     = 16;  // row index
	localparam int ROWS_W    = 17;  // row_count register
	localparam int COLS_W    = 11;  // column_count register
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 17;  // widest register

	localparam logic [ROWS_W-1:0] MAX_ROWS = 17'd65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

	// request codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_MATRIX = 1'b1;

	// stage enables handed to the multiply-accumulate datapath
	typedef struct packed {
		logic load_s1;  // matrix transaction accepted, capture operand
		logic load_s2;  // s1 -> s2 (products)
		logic load_s3;  // s2 -> s3 (complex terms)
		logic acc_upd;  // s3 retires into the accumulator
		logic acc_clr;  // retiring element closes its row
	} mac_ctl_t;

endpackage

// ===== hdl/cmvm_if.sv =====
interface cmvm_item_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [cmvm_pkg::DATA_W-1:0]  value_re;
	logic signed [cmvm_pkg::DATA_W-1:0]  value_im;

	modport source(output valid, req_type, value_re, value_im, input ready);
	modport sink(input valid, req_type, value_re, value_im, output ready);
endinterface

interface cmvm_result_if;
	logic                               valid;
	logic                               ready;
	logic [cmvm_pkg::ROW_W-1:0]         row_index;
	logic signed [cmvm_pkg::ACC_W-1:0]  sum_re;
	logic signed [cmvm_pkg::ACC_W-1:0]  sum_im;
	logic                               last_row;

	modport source(output valid, row_index, sum_re, sum_im, last_row, input ready);
	modport sink(input valid, row_index, sum_re, sum_im, last_row, output ready);
endinterface

// ===== hdl/complex_matrix_vector_multiply.sv =====
// Channel   Dir   Payload                                  Transaction
// items     in    req_type, value_re, value_im             valid & ready
// results   out   row_index, sum_re, sum_im, last_row      valid & ready
// cfg       in    cfg_index, cfg_data                      cfg_we
//
// One item per cycle while items.ready is high, loads and matrix elements alike.
// A row result shows on results after the row's last element passes the RAM read,
// multiply, term add and the accumulate into the output register.
// The vector store is a 1-read 1-write RAM; a load writes at its own
// transaction and a matrix element reads at its own, so no forwarding.
// Reset clears pointers and accumulator and sets both counts to one; the store is not cleared.
// Three stages plus the output register absorb a stalled results channel;
// items.ready drops only once all of them are full.
module complex_matrix_vector_multiply #(
	parameter int MAX_COLUMNS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	cmvm_item_if.sink                           items,
	cmvm_result_if.source                       results,
	input  logic                                cfg_we,
	input  logic [cmvm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmvm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CMP_W = (AW + 1 > cmvm_pkg::COLS_W) ? AW + 1 : cmvm_pkg::COLS_W;
	localparam int DW    = cmvm_pkg::DATA_W;
	localparam int RW    = cmvm_pkg::ROW_W;
	localparam int NW    = cmvm_pkg::ROWS_W;

	localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLUMNS);

	// effective counts, clamped at write time
	logic [NW-1:0]    rows_q;
	logic [CMP_W-1:0] cols_q;
	logic [NW-1:0]    rows_wr;
	logic [CMP_W-1:0] cols_wr;

	logic [AW-1:0] lp_q, cp_q;
	logic [RW-1:0] rp_q;

	logic             take, take_load, take_mat;
	logic [AW-1:0]    lp_eff, lp_nxt, cp_eff, cp_nxt;
	logic [CMP_W-1:0] lp_inc, cp_inc;
	logic [RW-1:0]    rp_eff, rp_nxt;
	logic             row_end, row_last;

	// pipeline control
	logic          v_s1, v_s2, v_s3;
	logic          end_s1, end_s2, end_s3;
	logic          last_s1, last_s2, last_s3;
	logic [RW-1:0] row_s1, row_s2, row_s3;
	logic          move1, move2, move3;

	logic [2*DW-1:0]             vec_s1;
	logic signed [cmvm_pkg::ACC_W-1:0] sum_re, sum_im;
	cmvm_pkg::mac_ctl_t          mac_ctl;

	// output register
	logic                              ov_q;
	logic [RW-1:0]                     out_row_q;
	logic signed [cmvm_pkg::ACC_W-1:0] out_re_q, out_im_q;
	logic                              out_last_q;

	// ---------------- configuration ----------------
	always_comb begin
		rows_wr = cfg_data[NW-1:0];
		if (rows_wr == '0) begin
			rows_wr = NW'(1);
		end else if (rows_wr > cmvm_pkg::MAX_ROWS) begin
			rows_wr = cmvm_pkg::MAX_ROWS;
		end
		cols_wr = CMP_W'(cfg_data[cmvm_pkg::COLS_W-1:0]);
		if (cols_wr == '0) begin
			cols_wr = CMP_W'(1);
		end else if (cols_wr > MAX_COLS_C) begin
			cols_wr = MAX_COLS_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= NW'(1);
			cols_q <= CMP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				cmvm_pkg::REG_ROW_COUNT:    rows_q <= rows_wr;
				cmvm_pkg::REG_COLUMN_COUNT: cols_q <= cols_wr;
				default: ;
			endcase
		end
	end

	// ---------------- stage handshake ----------------
	// a stage moves when the next one is empty or moving; only a row-closing
	// element needs room in the output register
	assign move3 = v_s3 && (!end_s3 || !ov_q || results.ready);
	assign move2 = v_s2 && (!v_s3 || move3);
	assign move1 = v_s1 && (!v_s2 || move2);

	assign items.ready = !v_s1 || move1;
	assign take        = items.valid && items.ready;
	assign take_load   = take && (items.req_type == cmvm_pkg::REQ_LOAD);
	assign take_mat    = take && (items.req_type == cmvm_pkg::REQ_MATRIX);

	// ---------------- pointers ----------------
	always_comb begin
		// load side: restart when the count shrank under the pointer
		lp_eff = (CMP_W'(lp_q) >= cols_q) ? '0 : lp_q;
		lp_inc = CMP_W'(lp_eff) + CMP_W'(1);
		lp_nxt = (lp_inc >= cols_q) ? '0 : lp_inc[AW-1:0];

		// matrix side: a column pointer past the count sits on the last column
		cp_eff  = (CMP_W'(cp_q) >= cols_q) ? AW'(cols_q - CMP_W'(1)) : cp_q;
		cp_inc  = CMP_W'(cp_eff) + CMP_W'(1);
		row_end = (cp_inc >= cols_q);
		cp_nxt  = row_end ? '0 : cp_inc[AW-1:0];

		rp_eff   = (NW'(rp_q) >= rows_q) ? '0 : rp_q;
		row_last = (NW'(rp_eff) + NW'(1) >= rows_q);
		rp_nxt   = row_last ? '0 : rp_eff + RW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			cp_q <= '0;
			rp_q <= '0;
		end else begin
			if (take_load) begin
				lp_q <= lp_nxt;
			end
			// a row pointer past a shrunk count restarts at the next element,
			// even when that element does not close the row
			if (take_mat) begin
				cp_q <= cp_nxt;
				rp_q <= row_end ? rp_nxt : rp_eff;
			end
		end
	end

	// ---------------- vector store ----------------
	cmvm_vec_ram #(
		.DEPTH (MAX_COLUMNS),
		.AW    (AW),
		.W     (2 * DW)
	) u_vec_ram (
		.clk   (clk),
		.we    (take_load),
		.waddr (lp_eff),
		.wdata ({items.value_im, items.value_re}),
		.re    (take_mat),
		.raddr (cp_eff),
		.rdata (vec_s1)
	);

	// ---------------- stage valids and tags ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take_mat) begin
				v_s1 <= 1'b1;
			end else if (move1) begin
				v_s1 <= 1'b0;
			end
			if (move1) begin
				v_s2 <= 1'b1;
			end else if (move2) begin
				v_s2 <= 1'b0;
			end
			if (move2) begin
				v_s3 <= 1'b1;
			end else if (move3) begin
				v_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_mat) begin
			end_s1  <= row_end;
			last_s1 <= row_last;
			row_s1  <= rp_eff;
		end
		if (move1) begin
			end_s2  <= end_s1;
			last_s2 <= last_s1;
			row_s2  <= row_s1;
		end
		if (move2) begin
			end_s3  <= end_s2;
			last_s3 <= last_s2;
			row_s3  <= row_s2;
		end
	end

	// ---------------- complex multiply-accumulate ----------------
	always_comb begin
		mac_ctl.load_s1 = take_mat;
		mac_ctl.load_s2 = move1;
		mac_ctl.load_s3 = move2;
		mac_ctl.acc_upd = move3;
		mac_ctl.acc_clr = end_s3;
	end

	cmvm_cmac u_cmac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_in   (items.value_re),
		.b_in   (items.value_im),
		.vec_s1 (vec_s1),
		.sum_re (sum_re),
		.sum_im (sum_im)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (move3 && end_s3) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move3 && end_s3) begin
			out_row_q  <= row_s3;
			out_re_q   <= sum_re;
			out_im_q   <= sum_im;
			out_last_q <= last_s3;
		end
	end

	assign results.valid     = ov_q;
	assign results.row_index = out_row_q;
	assign results.sum_re    = out_re_q;
	assign results.sum_im    = out_im_q;
	assign results.last_row  = out_last_q;

endmodule

// ===== hdl/cmvm_vec_ram.sv =====
module cmvm_vec_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/cmvm_cmac.sv =====
module cmvm_cmac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cmvm_pkg::mac_ctl_t                  ctl,
	input  logic signed [cmvm_pkg::DATA_W-1:0]  a_in,
	input  logic signed [cmvm_pkg::DATA_W-1:0]  b_in,
	input  logic [2*cmvm_pkg::DATA_W-1:0]       vec_s1,
	output logic signed [cmvm_pkg::ACC_W-1:0]   sum_re,
	output logic signed [cmvm_pkg::ACC_W-1:0]   sum_im
);

	localparam int DW = cmvm_pkg::DATA_W;
	localparam int AW = cmvm_pkg::ACC_W;

	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic signed [AW-1:0] p_ac_s2, p_bd_s2, p_bc_s2, p_ad_s2;
	logic signed [AW-1:0] term_re_s3, term_im_s3;
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	logic [AW:0]          wide_re, wide_im;

	assign c_s1 = signed'(vec_s1[DW-1:0]);
	assign d_s1 = signed'(vec_s1[2*DW-1:DW]);

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
		end
		if (ctl.load_s2) begin
			p_ac_s2 <= a_s1 * c_s1;
			p_bd_s2 <= b_s1 * d_s1;
			p_bc_s2 <= b_s1 * c_s1;
			p_ad_s2 <= a_s1 * d_s1;
		end
		// terms wrap at 64 bits; only the all-minimum corner can reach 2^63
		if (ctl.load_s3) begin
			term_re_s3 <= p_ac_s2 - p_bd_s2;
			term_im_s3 <= p_bc_s2 + p_ad_s2;
		end
	end

	// saturating add, one extra bit to see the overflow
	assign wide_re = {acc_re_q[AW-1], acc_re_q} + {term_re_s3[AW-1], term_re_s3};
	assign wide_im = {acc_im_q[AW-1], acc_im_q} + {term_im_s3[AW-1], term_im_s3};

	always_comb begin
		if (wide_re[AW] != wide_re[AW-1]) begin
			sum_re = wide_re[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			sum_re = signed'(wide_re[AW-1:0]);
		end
		if (wide_im[AW] != wide_im[AW-1]) begin
			sum_im = wide_im[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			sum_im = signed'(wide_im[AW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (ctl.acc_upd) begin
			acc_re_q <= ctl.acc_clr ? '0 : sum_re;
			acc_im_q <= ctl.acc_clr ? '0 : sum_im;
		end
	end

endmodule

// ===== hdl/cmvm_checker.sv =====
module cmvm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_ready,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic [cmvm_pkg::ROW_W-1:0]          res_row_index,
	input logic signed [cmvm_pkg::ACC_W-1:0]   res_sum_re,
	input logic signed [cmvm_pkg::ACC_W-1:0]   res_sum_im,
	input logic                                res_last_row,
	input logic                                cfg_we
);

	logic                       res_take;
	logic                       seen_q;
	logic [cmvm_pkg::ROW_W-1:0] exp_row_q;

	assign res_take = res_valid && res_ready;

	// expected next row index; a config write may restart the row count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			exp_row_q <= '0;
		end else if (cfg_we) begin
			seen_q <= 1'b0;
		end else if (res_take) begin
			seen_q    <= 1'b1;
			exp_row_q <= res_last_row ? '0 : res_row_index + cmvm_pkg::ROW_W'(1);
		end
	end

	// held result does not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_row_index)
			&& $stable(res_sum_re) && $stable(res_sum_im) && $stable(res_last_row))
		else $error("result changed while stalled");

	// with no result waiting the pipeline always drains, so items flow
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("items stalled with an empty result register");

	// rows come out in order and restart after the last one
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && seen_q |-> res_row_index == exp_row_q)
		else $error("row index out of sequence");

	// a result cannot follow reset release without any item in between
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid, 3) || $past(res_valid, 1)
			|| $past(item_valid, 4) || !$past(item_ready, 3) || !$past(item_ready, 4))
		else $error("result without a preceding transaction");

endmodule

bind complex_matrix_vector_multiply cmvm_checker u_cmvm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (items.valid),
	.item_ready    (items.ready),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.res_row_index (results.row_index),
	.res_sum_re    (results.sum_re),
	.res_sum_im    (results.sum_im),
	.res_last_row  (results.last_row),
	.cfg_we        (cfg_we)
);
